### design/assert_macros.svh
// Assertion helpers for the mapper core, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GCL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: cause at a clock edge, effect at the next.
`define GCL_ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

### design/gcl_pkg.sv
`timescale 1ns / 1ps

package gcl_pkg;

  // Event types and sync codes.
  localparam logic [15:0] TYPE_SYN = 16'd0;
  localparam logic [15:0] TYPE_KEY = 16'd1;
  localparam logic [9:0] SYNC_REPORT = 10'd0;
  localparam logic [9:0] SYNC_DROPPED = 10'd3;

  // Key codes.
  localparam logic [9:0] KEY_B_SOUTH = 10'd304;
  localparam logic [9:0] KEY_A_EAST = 10'd305;
  localparam logic [9:0] KEY_Y_NORTH = 10'd307;
  localparam logic [9:0] KEY_X_WEST = 10'd308;
  localparam logic [9:0] KEY_L1 = 10'd310;
  localparam logic [9:0] KEY_R1 = 10'd311;
  localparam logic [9:0] KEY_L2 = 10'd312;
  localparam logic [9:0] KEY_R2 = 10'd313;
  localparam logic [9:0] KEY_SELECT = 10'd314;
  localparam logic [9:0] KEY_START = 10'd315;
  localparam logic [9:0] KEY_MENU = 10'd316;
  localparam logic [9:0] KEY_UP = 10'd544;
  localparam logic [9:0] KEY_DOWN = 10'd545;
  localparam logic [9:0] KEY_LEFT = 10'd546;
  localparam logic [9:0] KEY_RIGHT = 10'd547;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  localparam logic KIND_MEDIA = 1'b0;
  localparam logic KIND_RESYNC = 1'b1;

  typedef enum logic [4:0] {
    CMD_PAUSE    = 5'd0,
    CMD_STEP     = 5'd1,
    CMD_PROGRESS = 5'd2,
    CMD_FWD_S    = 5'd3,
    CMD_BACK_S   = 5'd4,
    CMD_FWD_L    = 5'd5,
    CMD_BACK_L   = 5'd6,
    CMD_CHAP_P   = 5'd7,
    CMD_CHAP_N   = 5'd8,
    CMD_LIST_P   = 5'd9,
    CMD_LIST_N   = 5'd10,
    CMD_SUB      = 5'd11,
    CMD_SUBVIS   = 5'd12,
    CMD_AUDIO    = 5'd13,
    CMD_VOL_D    = 5'd14,
    CMD_VOL_U    = 5'd15,
    CMD_BRI_D    = 5'd16,
    CMD_BRI_U    = 5'd17,
    CMD_CON_D    = 5'd18,
    CMD_CON_U    = 5'd19,
    CMD_SAT_D    = 5'd20,
    CMD_SAT_U    = 5'd21
  } cmd_t;

  // Deferred action of select or start, fired on release.
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SUB    = 2'd1,
    ACT_AUDIO  = 2'd2,
    ACT_SUBVIS = 2'd3
  } act_t;

  typedef struct packed {
    logic               operation;
    logic [15:0]        event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
    logic               snap_menu;
    logic               snap_left;
    logic               snap_right;
    logic               snap_select;
    logic               snap_start;
  } evt_item_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] command;
    logic       last;
  } cmd_item_t;

  typedef struct packed {
    logic menu_down;
    logic left_down;
    logic right_down;
    logic left_consumed;
    logic right_consumed;
    logic select_down;
    logic start_down;
    logic chord_latch;
    logic discarding;
    act_t select_action;
    act_t start_action;
  } map_state_t;

  typedef struct packed {
    logic hit;
    cmd_t cmd;
  } lut_t;

  function automatic lut_t base_cmd(input logic [9:0] code);
    lut_t r;
    r.hit = 1'b1;
    unique case (code)
      KEY_A_EAST:  r.cmd = CMD_PAUSE;
      KEY_B_SOUTH: r.cmd = CMD_STEP;
      KEY_X_WEST:  r.cmd = CMD_AUDIO;
      KEY_Y_NORTH: r.cmd = CMD_PROGRESS;
      KEY_LEFT:    r.cmd = CMD_BACK_S;
      KEY_RIGHT:   r.cmd = CMD_FWD_S;
      KEY_DOWN:    r.cmd = CMD_BACK_L;
      KEY_UP:      r.cmd = CMD_FWD_L;
      KEY_L2:      r.cmd = CMD_CHAP_P;
      KEY_R2:      r.cmd = CMD_CHAP_N;
      default: begin
        r.hit = 1'b0;
        r.cmd = CMD_PAUSE;
      end
    endcase
    return r;
  endfunction

  function automatic lut_t shift_cmd(input logic [9:0] code);
    lut_t r;
    r.hit = 1'b1;
    unique case (code)
      KEY_LEFT:    r.cmd = CMD_PAUSE;
      KEY_DOWN:    r.cmd = CMD_STEP;
      KEY_UP:      r.cmd = CMD_AUDIO;
      KEY_RIGHT:   r.cmd = CMD_PROGRESS;
      KEY_A_EAST:  r.cmd = CMD_FWD_S;
      KEY_B_SOUTH: r.cmd = CMD_BACK_L;
      KEY_X_WEST:  r.cmd = CMD_FWD_L;
      KEY_Y_NORTH: r.cmd = CMD_BACK_S;
      KEY_L2:      r.cmd = CMD_LIST_P;
      KEY_R2:      r.cmd = CMD_LIST_N;
      default: begin
        r.hit = 1'b0;
        r.cmd = CMD_PAUSE;
      end
    endcase
    return r;
  endfunction

  function automatic lut_t picture_cmd(input logic [9:0] code);
    lut_t r;
    r.hit = 1'b1;
    unique case (code)
      KEY_LEFT:  r.cmd = CMD_CON_D;
      KEY_RIGHT: r.cmd = CMD_CON_U;
      KEY_DOWN:  r.cmd = CMD_SAT_D;
      KEY_UP:    r.cmd = CMD_SAT_U;
      default: begin
        r.hit = 1'b0;
        r.cmd = CMD_PAUSE;
      end
    endcase
    return r;
  endfunction

  function automatic lut_t action_cmd(input act_t act);
    lut_t r;
    r.hit = 1'b1;
    unique case (act)
      ACT_SUB:    r.cmd = CMD_SUB;
      ACT_AUDIO:  r.cmd = CMD_AUDIO;
      ACT_SUBVIS: r.cmd = CMD_SUBVIS;
      default: begin
        r.hit = 1'b0;
        r.cmd = CMD_PAUSE;
      end
    endcase
    return r;
  endfunction

endpackage

### design/gcl_map.sv
`timescale 1ns / 1ps

// Combinational mapping of one transaction: next state and up to two results.
module gcl_map (
  input  gcl_pkg::map_state_t st,
  input  gcl_pkg::evt_item_t  item,
  output gcl_pkg::map_state_t st_next,
  output logic [1:0]          res_cnt,
  output gcl_pkg::cmd_item_t  res0,
  output gcl_pkg::cmd_item_t  res1
);

  logic         v_one;
  logic         v_zero;
  logic         layered;
  logic         chord_upd;
  gcl_pkg::lut_t sel;
  gcl_pkg::lut_t pic;

  assign v_one   = (item.event_value == 32'sd1);
  assign v_zero  = (item.event_value == 32'sd0);
  assign layered = st.left_down | st.right_down;
  assign pic     = gcl_pkg::picture_cmd(item.event_code);

  always_comb begin
    st_next   = st;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    chord_upd = 1'b0;
    sel       = '0;

    if (item.operation == gcl_pkg::OP_SNAPSHOT) begin
      st_next                = '0;
      st_next.menu_down      = item.snap_menu;
      st_next.left_down      = item.snap_left;
      st_next.right_down     = item.snap_right;
      st_next.left_consumed  = item.snap_left;
      st_next.right_consumed = item.snap_right;
      st_next.select_down    = item.snap_select;
      st_next.start_down     = item.snap_start;
      st_next.chord_latch    = item.snap_select & item.snap_start;
    end else if (st.discarding) begin
      if (item.event_type == gcl_pkg::TYPE_SYN && item.event_code == gcl_pkg::SYNC_REPORT) begin
        st_next.discarding = 1'b0;
        res0.kind          = gcl_pkg::KIND_RESYNC;
        res_cnt            = 2'd1;
      end
    end else if (item.event_type == gcl_pkg::TYPE_SYN &&
                 item.event_code == gcl_pkg::SYNC_DROPPED) begin
      st_next            = '0;
      st_next.discarding = 1'b1;
    end else if (item.event_type == gcl_pkg::TYPE_KEY) begin
      if (item.event_code == gcl_pkg::KEY_SELECT) begin
        if (v_one) begin
          st_next.select_down   = 1'b1;
          st_next.select_action = layered ? gcl_pkg::ACT_AUDIO : gcl_pkg::ACT_SUB;
          if (layered) begin
            st_next.left_consumed  = st.left_consumed | st.left_down;
            st_next.right_consumed = st.right_consumed | st.right_down;
          end
          chord_upd = 1'b1;
        end else if (v_zero && st.select_down) begin
          st_next.select_down   = 1'b0;
          st_next.select_action = gcl_pkg::ACT_NONE;
          if (!st.chord_latch && !st.start_down) begin
            sel = gcl_pkg::action_cmd(st.select_action);
          end
          chord_upd = 1'b1;
        end
      end else if (item.event_code == gcl_pkg::KEY_START) begin
        if (v_one) begin
          st_next.start_down   = 1'b1;
          st_next.start_action = gcl_pkg::ACT_SUBVIS;
          if (layered) begin
            st_next.left_consumed  = st.left_consumed | st.left_down;
            st_next.right_consumed = st.right_consumed | st.right_down;
          end
          chord_upd = 1'b1;
        end else if (v_zero && st.start_down) begin
          st_next.start_down   = 1'b0;
          st_next.start_action = gcl_pkg::ACT_NONE;
          if (!st.chord_latch && !st.select_down) begin
            sel = gcl_pkg::action_cmd(st.start_action);
          end
          chord_upd = 1'b1;
        end
      end else if (item.event_code == gcl_pkg::KEY_MENU) begin
        st_next.menu_down = !v_zero;
        if (v_one) begin
          // Held, untapped shoulders turn into brightness; both may fire at once.
          if (st.left_down && !st.left_consumed) begin
            st_next.left_consumed = 1'b1;
            res0.command          = gcl_pkg::CMD_BRI_D;
            res_cnt               = 2'd1;
          end
          if (st.right_down && !st.right_consumed) begin
            st_next.right_consumed = 1'b1;
            if (res_cnt == 2'd1) begin
              res1.command = gcl_pkg::CMD_BRI_U;
              res_cnt      = 2'd2;
            end else begin
              res0.command = gcl_pkg::CMD_BRI_U;
              res_cnt      = 2'd1;
            end
          end
        end
      end else if (item.event_code == gcl_pkg::KEY_L1) begin
        if (v_one) begin
          st_next.left_down     = 1'b1;
          st_next.left_consumed = st.menu_down;
          sel.hit               = st.menu_down;
          sel.cmd               = gcl_pkg::CMD_BRI_D;
        end else if (v_zero && st.left_down) begin
          sel.hit               = !st.left_consumed;
          sel.cmd               = gcl_pkg::CMD_VOL_D;
          st_next.left_down     = 1'b0;
          st_next.left_consumed = 1'b0;
        end
      end else if (item.event_code == gcl_pkg::KEY_R1) begin
        if (v_one) begin
          st_next.right_down     = 1'b1;
          st_next.right_consumed = st.menu_down;
          sel.hit                = st.menu_down;
          sel.cmd                = gcl_pkg::CMD_BRI_U;
        end else if (v_zero && st.right_down) begin
          sel.hit                = !st.right_consumed;
          sel.cmd                = gcl_pkg::CMD_VOL_U;
          st_next.right_down     = 1'b0;
          st_next.right_consumed = 1'b0;
        end
      end else if (v_one) begin
        if (st.menu_down && pic.hit) begin
          st_next.left_consumed  = st.left_consumed | st.left_down;
          st_next.right_consumed = st.right_consumed | st.right_down;
          sel                    = pic;
        end else if (layered) begin
          st_next.left_consumed  = st.left_consumed | st.left_down;
          st_next.right_consumed = st.right_consumed | st.right_down;
          sel                    = gcl_pkg::shift_cmd(item.event_code);
        end else begin
          sel = gcl_pkg::base_cmd(item.event_code);
        end
      end
    end

    // The exit chord cancels both pending actions while select and start are held.
    if (chord_upd) begin
      if (st_next.select_down && st_next.start_down) begin
        st_next.chord_latch   = 1'b1;
        st_next.select_action = gcl_pkg::ACT_NONE;
        st_next.start_action  = gcl_pkg::ACT_NONE;
      end else if (!st_next.select_down && !st_next.start_down) begin
        st_next.chord_latch = 1'b0;
      end
    end

    if (sel.hit) begin
      res0.kind    = gcl_pkg::KIND_MEDIA;
      res0.command = sel.cmd;
      res_cnt      = 2'd1;
    end

    if (res_cnt == 2'd1) begin
      res0.last = 1'b1;
    end
    if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end
  end

endmodule

### design/gamepad_chord_layer_mapper_core.sv
// Flow: an accepted event waits in the input register until the result buffer has room;
// its results are then registered into the buffer and presented on cmd from slot0.
// Throughput: one event per cycle while cmd_ready is high; an event that yields two results
// (menu press with both shoulders held, untapped) holds the next one back while slot1 drains.
// Reset (rst, synchronous, active high) clears all key and chord state, the discard flag,
// the input valid flag and the result count; no results are pending after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gamepad_chord_layer_mapper_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_ready,
  input  gcl_pkg::evt_item_t  evt,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output gcl_pkg::cmd_item_t  cmd
);

  // Input register: one event transaction waiting to be mapped.
  logic                s_valid;
  gcl_pkg::evt_item_t  s_item;

  // Mapper state, updated once per mapped transaction.
  gcl_pkg::map_state_t st;
  gcl_pkg::map_state_t st_next;

  // Result buffer: slot0 is presented on cmd, slot1 holds the second result of an event.
  logic [1:0]          cnt;
  gcl_pkg::cmd_item_t  slot0;
  gcl_pkg::cmd_item_t  slot1;

  logic [1:0]          res_cnt;
  gcl_pkg::cmd_item_t  res0;
  gcl_pkg::cmd_item_t  res1;

  logic                pop;
  logic                process;

  gcl_map u_map (
    .st      (st),
    .item    (s_item),
    .st_next (st_next),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  // The held event is mapped once the buffer is empty, or is emptied by this cycle's
  // output transaction. The buffer then never needs more than two slots.
  assign pop       = (cnt != 2'd0) && cmd_ready;
  assign process   = s_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && cmd_ready));
  assign evt_ready = !s_valid || process;

  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      st      <= '0;
      cnt     <= 2'd0;
    end else begin
      if (evt_ready) begin
        s_valid <= evt_valid;
      end
      if (process) begin
        st  <= st_next;
        cnt <= res_cnt;
      end else if (pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Payload registers carry no reset; the valid flags above qualify them.
  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      s_item <= evt;
    end
    if (process) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  // A result that is not the final one of its event always has its follower queued.
  `GCL_ASSERT(a_first_has_follower, clk, rst,
              !(cmd_valid && !cmd.last) || (cnt == 2'd2), "non-final result without follower")

  // The queued second result is always the final one of its event.
  `GCL_ASSERT(a_second_is_last, clk, rst,
              (cnt != 2'd2) || slot1.last, "queued second result not marked last")

  // A resync request is always the only result of its event.
  `GCL_ASSERT(a_resync_alone, clk, rst,
              !(cmd_valid && cmd.kind == gcl_pkg::KIND_RESYNC) || (cmd.last && cnt == 2'd1),
              "resync request not alone")

  // A snapshot always leaves the discard mode.
  `GCL_ASSERT_NEXT(a_snapshot_resumes, clk, rst,
                   process && s_item.operation == gcl_pkg::OP_SNAPSHOT, !st.discarding,
                   "discarding still set after snapshot")

endmodule
